[hw/rtl/urxft_pkg.sv]
`default_nettype none

package urxft_pkg;

   // Field widths
   localparam int FUNC_W = 3;
   localparam int BYTE_W = 8;
   localparam int CODE_W = 3;
   localparam int ERR_W  = 2;
   localparam int CNT_W  = 16;

   // Event codes on req_func
   localparam logic [FUNC_W-1:0] FUNC_RX_BYTE   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ_NB   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ_TMO  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_TICK      = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_FLUSH     = 3'd4;

   // Read outcome codes on rsp_code
   localparam logic [CODE_W-1:0] CODE_NONE    = 3'd0;
   localparam logic [CODE_W-1:0] CODE_DATA    = 3'd1;
   localparam logic [CODE_W-1:0] CODE_EMPTY   = 3'd2;
   localparam logic [CODE_W-1:0] CODE_TIMEOUT = 3'd3;
   localparam logic [CODE_W-1:0] CODE_WAIT    = 3'd4;

   // Error codes on rsp_error_code
   localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd1;
   localparam logic [ERR_W-1:0] ERR_TIMEOUT  = 2'd2;

   localparam logic [CNT_W-1:0] TIMEOUT_RESET = 16'd1000;
   localparam logic [CNT_W-1:0] CNT_MAX       = 16'hFFFF;

   // Ring commands, at most one per cycle
   typedef struct packed {
      logic push;
      logic pop;
      logic flush;
   } ring_ctrl_type;

endpackage

`default_nettype wire

[hw/rtl/uart_rx_fifo_timed_read_core.sv]
`default_nettype none

// Channel   Direction  Ports                                   Transfer when
// req_      in         req_func, req_rx_byte                   req_valid && !req_stall
// rsp_      out        rsp_code, rsp_data, rsp_have_data,      rsp_valid && !rsp_stall
//                      rsp_error_code, rsp_timed_out, rsp_fill
// csr_      in         csr_wdata (timeout in ticks)            csr_we
//
// Cycles: one event per clock while rsp_stall is low; an event is taken into the input
//   register, then moves into the result register, from which it transfers out. The
//   ring's registered read port keeps the oldest byte prefetched, so a read need not
//   wait for the memory.
// Reset: synchronous; empties the ring, clears error, flag and wait, timeout back to 1000.
// Stalls: rsp_stall holds the result register; req_stall rises only when the input
//   register holds an event that cannot move into a held result register.

module uart_rx_fifo_timed_read_core #(
   parameter int QUEUE_DEPTH = 8
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // event channel
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [urxft_pkg::FUNC_W-1:0]          req_func,
   input  wire  [urxft_pkg::BYTE_W-1:0]          req_rx_byte,
   // result channel
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [urxft_pkg::CODE_W-1:0]          rsp_code,
   output logic [urxft_pkg::BYTE_W-1:0]          rsp_data,
   output logic                                  rsp_have_data,
   output logic [urxft_pkg::ERR_W-1:0]           rsp_error_code,
   output logic                                  rsp_timed_out,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]      rsp_fill,
   // timeout register
   input  wire                                   csr_we,
   input  wire  [urxft_pkg::CNT_W-1:0]           csr_wdata
);
   import urxft_pkg::*;

   localparam int FILL_W = $clog2(QUEUE_DEPTH+1);

   // Input register
   logic              in_valid_ff, in_valid_in;
   logic [FUNC_W-1:0] in_func_ff;
   logic [BYTE_W-1:0] in_byte_ff;

   // Block state
   logic [CNT_W-1:0]  timeout_ms_ff, timeout_ms_in;
   logic [ERR_W-1:0]  last_error_ff, last_error_in;
   logic              timeout_flag_ff, timeout_flag_in;
   logic              wait_active_ff, wait_active_in;
   logic [CNT_W-1:0]  wait_count_ff, wait_count_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0] rsp_code_ff, rsp_code_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_have_ff;
   logic [ERR_W-1:0]  rsp_err_ff;
   logic              rsp_tmo_ff;
   logic [FILL_W-1:0] rsp_fill_ff;

   ring_ctrl_type     ring_ctrl;
   logic [BYTE_W-1:0] ring_head;
   logic [FILL_W-1:0] ring_fill;
   logic [FILL_W-1:0] fill_after;
   logic              has_data;
   logic              ring_full;
   logic              advance;
   logic              req_take;

   assign has_data  = (ring_fill != '0);
   assign ring_full = (ring_fill == FILL_W'(QUEUE_DEPTH));

   // Move the held event on whenever the result register is empty or being drained.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in = req_take || (in_valid_ff && !advance);

   urxft_ring #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ring (
      .clock (clock),
      .reset (reset),
      .ctrl  (ring_ctrl),
      .wdata (in_byte_ff),
      .head  (ring_head),
      .fill  (ring_fill)
   );

   // Event decode: one pass from the input register into the result register.
   always_comb begin
      ring_ctrl       = '0;
      last_error_in   = last_error_ff;
      timeout_flag_in = timeout_flag_ff;
      wait_active_in  = wait_active_ff;
      wait_count_in   = wait_count_ff;
      rsp_code_in     = CODE_NONE;
      rsp_data_in     = '0;
      fill_after      = ring_fill;

      if (advance) begin
         case (in_func_ff)
            FUNC_RX_BYTE: begin
               if (!ring_full) begin
                  ring_ctrl.push = 1'b1;
                  fill_after     = ring_fill + FILL_W'(1);
                  last_error_in  = ERR_NONE;
               end else begin
                  // drop the byte
                  last_error_in  = ERR_OVERFLOW;
               end
            end
            FUNC_READ_NB: begin
               if (has_data) begin
                  ring_ctrl.pop = 1'b1;
                  fill_after    = ring_fill - FILL_W'(1);
                  rsp_data_in   = ring_head;
                  rsp_code_in   = CODE_DATA;
               end else begin
                  rsp_code_in   = CODE_EMPTY;
               end
            end
            FUNC_READ_TMO: begin
               // restart: clear status and cancel any wait in progress
               timeout_flag_in = 1'b0;
               last_error_in   = ERR_NONE;
               wait_active_in  = 1'b0;
               wait_count_in   = '0;
               if (has_data) begin
                  ring_ctrl.pop = 1'b1;
                  fill_after    = ring_fill - FILL_W'(1);
                  rsp_data_in   = ring_head;
                  rsp_code_in   = CODE_DATA;
               end else if (timeout_ms_ff == '0) begin
                  last_error_in   = ERR_TIMEOUT;
                  timeout_flag_in = 1'b1;
                  rsp_code_in     = CODE_TIMEOUT;
               end else begin
                  wait_active_in  = 1'b1;
                  rsp_code_in     = CODE_WAIT;
               end
            end
            FUNC_TICK: begin
               if (wait_active_ff) begin
                  // saturate the tick count
                  if (wait_count_ff != CNT_MAX) begin
                     wait_count_in = wait_count_ff + CNT_W'(1);
                  end
                  if (has_data) begin
                     ring_ctrl.pop  = 1'b1;
                     fill_after     = ring_fill - FILL_W'(1);
                     rsp_data_in    = ring_head;
                     rsp_code_in    = CODE_DATA;
                     wait_active_in = 1'b0;
                  end else if (wait_count_in >= timeout_ms_ff) begin
                     last_error_in   = ERR_TIMEOUT;
                     timeout_flag_in = 1'b1;
                     wait_active_in  = 1'b0;
                     rsp_code_in     = CODE_TIMEOUT;
                  end else begin
                     rsp_code_in     = CODE_WAIT;
                  end
               end
            end
            FUNC_FLUSH: begin
               // empty the ring, keep a pending wait running
               ring_ctrl.flush = 1'b1;
               fill_after      = '0;
            end
            default: begin
            end
         endcase
      end

      // A register write clears the error code.
      if (csr_we) begin
         last_error_in = ERR_NONE;
      end
   end

   assign timeout_ms_in = csr_we ? csr_wdata : timeout_ms_ff;
   assign rsp_valid_in  = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         timeout_ms_ff   <= TIMEOUT_RESET;
         last_error_ff   <= ERR_NONE;
         timeout_flag_ff <= 1'b0;
         wait_active_ff  <= 1'b0;
         wait_count_ff   <= '0;
      end else begin
         in_valid_ff     <= in_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         timeout_ms_ff   <= timeout_ms_in;
         last_error_ff   <= last_error_in;
         timeout_flag_ff <= timeout_flag_in;
         wait_active_ff  <= wait_active_in;
         wait_count_ff   <= wait_count_in;
      end
   end

   // Payload registers: load on transfer in, load the result when the event moves on.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff <= req_func;
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         rsp_code_ff <= rsp_code_in;
         rsp_data_ff <= rsp_data_in;
         rsp_have_ff <= (fill_after != '0);
         rsp_err_ff  <= last_error_in;
         rsp_tmo_ff  <= timeout_flag_in;
         rsp_fill_ff <= fill_after;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code       = rsp_code_ff;
   assign rsp_data       = rsp_data_ff;
   assign rsp_have_data  = rsp_have_ff;
   assign rsp_error_code = rsp_err_ff;
   assign rsp_timed_out  = rsp_tmo_ff;
   assign rsp_fill       = rsp_fill_ff;

endmodule

`default_nettype wire

[hw/rtl/urxft_ring.sv]
`default_nettype none

module urxft_ring #(
   parameter int QUEUE_DEPTH = 8
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  urxft_pkg::ring_ctrl_type              ctrl,
   input  wire  [urxft_pkg::BYTE_W-1:0]          wdata,
   output logic [urxft_pkg::BYTE_W-1:0]          head,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]      fill
);
   import urxft_pkg::*;

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH+1);

   logic [BYTE_W-1:0] mem [QUEUE_DEPTH];

   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [BYTE_W-1:0] head_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (ctrl.flush) begin
         wr_ptr_in = '0;
         rd_ptr_in = '0;
         fill_in   = '0;
      end else if (ctrl.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         fill_in   = fill_ff + FILL_W'(1);
      end else if (ctrl.pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         fill_in   = fill_ff - FILL_W'(1);
      end
   end

   // Keep the oldest byte prefetched; forward a byte written to the slot being fetched.
   always_ff @(posedge clock) begin
      if (ctrl.push && !ctrl.flush) begin
         mem[wr_ptr_ff] <= wdata;
      end
      if (ctrl.push && !ctrl.flush && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= wdata;
      end else begin
         head_ff <= mem[rd_ptr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   assign head = head_ff;
   assign fill = fill_ff;

endmodule

`default_nettype wire

[hw/rtl/urxft_checker.sv]
`default_nettype none

module urxft_checker #(
   parameter int QUEUE_DEPTH = 8
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   rsp_valid,
   input  wire                                   rsp_stall,
   input  wire  [urxft_pkg::CODE_W-1:0]          rsp_code,
   input  wire  [urxft_pkg::BYTE_W-1:0]          rsp_data,
   input  wire                                   rsp_have_data,
   input  wire  [urxft_pkg::ERR_W-1:0]           rsp_error_code,
   input  wire                                   rsp_timed_out,
   input  wire  [$clog2(QUEUE_DEPTH+1)-1:0]      rsp_fill
);
   import urxft_pkg::*;

   localparam int FILL_W = $clog2(QUEUE_DEPTH+1);

   // A stalled result stays valid and holds its code, data, fill and error code.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code) && $stable(rsp_data)
         && $stable(rsp_fill) && $stable(rsp_error_code))
      else $error("result changed while stalled");

   a_have_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_have_data == (rsp_fill != '0))
      else $error("have_data disagrees with fill");

   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fill <= FILL_W'(QUEUE_DEPTH))
      else $error("fill above queue depth");

   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_code != CODE_DATA |-> rsp_data == '0)
      else $error("data without delivery");

   a_timeout_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_code == CODE_TIMEOUT |-> rsp_timed_out
         && rsp_error_code == ERR_TIMEOUT)
      else $error("timeout result without timeout status");

endmodule

bind uart_rx_fifo_timed_read_core urxft_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_urxft_checker (.*);

`default_nettype wire
